// ===== rtl/lpc_pkg.sv =====
`default_nettype none

package lpc_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int COORD_W    = 12;
    localparam int POS_W      = 14;
    localparam int DIM_W      = 13;
    localparam int AREA_W     = 2 * DIM_W;
    localparam int ROWOFF_W   = POS_W + DIM_W;
    localparam int LIN_W      = ROWOFF_W + 1;
    localparam int ADDR_W     = 24;
    localparam int PIX_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int STAGES     = 4;

    localparam logic [7:0] ALPHA_MAX = 8'hFF;

    typedef enum logic [1:0] {
        MODE_COPY     = 2'd0,
        MODE_FADE_IN  = 2'd1,
        MODE_FADE_OUT = 2'd2
    } lpc_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE         = 3'd0,
        CFG_GLOBAL_ALPHA = 3'd1,
        CFG_OFFSET_X     = 3'd2,
        CFG_OFFSET_Y     = 3'd3,
        CFG_FRAME_WIDTH  = 3'd4,
        CFG_FRAME_HEIGHT = 3'd5
    } lpc_cfg_idx_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic [7:0]       global_alpha;
        logic [DIM_W-1:0] offset_x;
        logic [DIM_W-1:0] offset_y;
        logic [DIM_W-1:0] frame_width;
        logic [DIM_W-1:0] frame_height;
    } lpc_cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [PIX_W-1:0]   src_pixel;
        logic [PIX_W-1:0]   dest_pixel;
    } lpc_item_t;

    typedef struct packed {
        logic              write_enable;
        logic [ADDR_W-1:0] address;
        logic [PIX_W-1:0]  out_pixel;
    } lpc_result_t;

    // exact floor(v / 255) for v up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] t;
        t = {1'b0, v} + 17'(v[15:8]) + 17'd1;
        return t[15:8];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lpc_stream_if.sv =====
`default_nettype none

interface lpc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/logo_pixel_compositor.sv =====
// Throughput: one request per cycle; the four-stage pipeline (coordinate add,
// multiply, sum, divide-by-255 and bounds check) stalls only on result backpressure.
// Reset: rst_n async active low clears all stage valid bits and loads
// register defaults (copy mode, alpha 255, no offset, 1024x768 frame).
`default_nettype none

module logo_pixel_compositor (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [lpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [lpc_pkg::CFG_DATA_W-1:0]   cfg_data,
    lpc_stream_if.sink                            item,
    lpc_stream_if.source                          result
);
    import lpc_pkg::*;

    lpc_cfg_t            cfg_reg;
    logic [STAGES-1:0]   valid_reg, valid_next;
    logic [STAGES-1:0]   stage_rdy, stage_in, en;
    logic                ok;
    logic [ADDR_W-1:0]   address;
    logic [PIX_W-1:0]    pixel;
    lpc_item_t           item_data;

    assign item_data = item.data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode         <= MODE_COPY;
            cfg_reg.global_alpha <= ALPHA_MAX;
            cfg_reg.offset_x     <= '0;
            cfg_reg.offset_y     <= '0;
            cfg_reg.frame_width  <= DIM_W'(1024);
            cfg_reg.frame_height <= DIM_W'(768);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:         cfg_reg.mode         <= cfg_data[1:0];
                CFG_GLOBAL_ALPHA: cfg_reg.global_alpha <= cfg_data[7:0];
                CFG_OFFSET_X:     cfg_reg.offset_x     <= cfg_data;
                CFG_OFFSET_Y:     cfg_reg.offset_y     <= cfg_data;
                CFG_FRAME_WIDTH:  cfg_reg.frame_width  <= cfg_data;
                CFG_FRAME_HEIGHT: cfg_reg.frame_height <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        stage_rdy[STAGES-1] = !valid_reg[STAGES-1] || result.ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            stage_rdy[k] = !valid_reg[k] || stage_rdy[k+1];
        end
        stage_in = {valid_reg[STAGES-2:0], item.valid};
        en       = stage_rdy & stage_in;
        for (int k = 0; k < STAGES; k++)
        begin
            valid_next[k] = stage_rdy[k] ? stage_in[k] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    lpc_addr_path u_addr (
        .clk     (clk),
        .en      (en),
        .cfg     (cfg_reg),
        .col     (item_data.col),
        .row     (item_data.row),
        .ok      (ok),
        .address (address)
    );

    lpc_color_path u_color (
        .clk        (clk),
        .en         (en),
        .cfg        (cfg_reg),
        .src_pixel  (item_data.src_pixel),
        .dest_pixel (item_data.dest_pixel),
        .pixel      (pixel)
    );

    assign item.ready                = stage_rdy[0];
    assign result.valid              = valid_reg[STAGES-1];
    assign result.data.write_enable  = ok;
    assign result.data.address       = address;
    assign result.data.out_pixel     = ok ? pixel : '0;

endmodule

`default_nettype wire

// ===== rtl/lpc_addr_path.sv =====
`default_nettype none

module lpc_addr_path (
    input  wire logic                          clk,
    input  wire logic [lpc_pkg::STAGES-1:0]    en,
    input  wire lpc_pkg::lpc_cfg_t             cfg,
    input  wire logic [lpc_pkg::COORD_W-1:0]   col,
    input  wire logic [lpc_pkg::COORD_W-1:0]   row,
    output logic                               ok,
    output logic [lpc_pkg::ADDR_W-1:0]         address
);
    import lpc_pkg::*;

    logic [POS_W-1:0]    x0_reg, y0_reg, x1_reg, x0_next, y0_next;
    logic                ok0_reg, ok1_reg, ok2_reg, ok3_reg, ok0_next, ok3_next;
    logic [ROWOFF_W-1:0] yfw1_reg, yfw1_next;
    logic [AREA_W-1:0]   area1_reg, area2_reg, area1_next;
    logic [LIN_W-1:0]    lin2_reg, lin2_next;
    logic [ADDR_W-1:0]   addr3_reg, addr3_next;
    logic                use_off, mode_ok;

    always_comb
    begin
        use_off  = (cfg.mode == MODE_COPY) || (cfg.mode == MODE_FADE_IN);
        mode_ok  = use_off || (cfg.mode == MODE_FADE_OUT);
        x0_next  = POS_W'(col) + (use_off ? POS_W'(cfg.offset_x) : '0);
        y0_next  = POS_W'(row) + (use_off ? POS_W'(cfg.offset_y) : '0);
        ok0_next = mode_ok && ({2'b00, col} < POS_W'(MAX_DIM))
                           && ({2'b00, row} < POS_W'(MAX_DIM));
        yfw1_next  = ROWOFF_W'(y0_reg) * ROWOFF_W'(cfg.frame_width);
        area1_next = AREA_W'(cfg.frame_width) * AREA_W'(cfg.frame_height);
        lin2_next  = LIN_W'(yfw1_reg) + LIN_W'(x1_reg);
        ok3_next   = ok2_reg && (lin2_reg < LIN_W'(area2_reg))
                             && (lin2_reg[LIN_W-1:ADDR_W] == '0);
        addr3_next = ok3_next ? lin2_reg[ADDR_W-1:0] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x0_reg  <= x0_next;
            y0_reg  <= y0_next;
            ok0_reg <= ok0_next;
        end
        if (en[1])
        begin
            x1_reg    <= x0_reg;
            yfw1_reg  <= yfw1_next;
            area1_reg <= area1_next;
            ok1_reg   <= ok0_reg;
        end
        if (en[2])
        begin
            lin2_reg  <= lin2_next;
            area2_reg <= area1_reg;
            ok2_reg   <= ok1_reg;
        end
        if (en[3])
        begin
            addr3_reg <= addr3_next;
            ok3_reg   <= ok3_next;
        end
    end

    assign ok      = ok3_reg;
    assign address = addr3_reg;

endmodule

`default_nettype wire

// ===== rtl/lpc_color_path.sv =====
`default_nettype none

module lpc_color_path (
    input  wire logic                        clk,
    input  wire logic [lpc_pkg::STAGES-1:0]  en,
    input  wire lpc_pkg::lpc_cfg_t           cfg,
    input  wire logic [lpc_pkg::PIX_W-1:0]   src_pixel,
    input  wire logic [lpc_pkg::PIX_W-1:0]   dest_pixel,
    output logic [lpc_pkg::PIX_W-1:0]        pixel
);
    import lpc_pkg::*;

    logic [PIX_W-1:0] src0_reg, src1_reg, src2_reg;
    logic [23:0]      dst0_reg, dst1_reg;
    logic [15:0]      sa0_reg, sa0_next;
    logic [15:0]      fo0_reg [3];
    logic [15:0]      fo0_next [3];
    logic [7:0]       a1_reg, a1_next;
    logic [7:0]       fo1_reg [3];
    logic [7:0]       fo1_next [3];
    logic [7:0]       fo2_reg [3];
    logic [15:0]      mix2_reg [3];
    logic [15:0]      mix2_next [3];
    logic [PIX_W-1:0] pix3_reg, pix3_next;
    logic [23:0]      fade_in_rgb, fade_out_rgb;

    always_comb
    begin
        sa0_next = 16'(src_pixel[31:24]) * 16'(cfg.global_alpha);
        a1_next  = div255(sa0_reg);
        for (int c = 0; c < 3; c++)
        begin
            fo0_next[c]  = 16'(src_pixel[8*c +: 8]) * 16'(cfg.global_alpha);
            fo1_next[c]  = div255(fo0_reg[c]);
            mix2_next[c] = 16'(src1_reg[8*c +: 8]) * 16'(a1_reg)
                         + 16'(dst1_reg[8*c +: 8]) * 16'(ALPHA_MAX - a1_reg);
            fade_in_rgb[8*c +: 8]  = div255(mix2_reg[c]);
            fade_out_rgb[8*c +: 8] = fo2_reg[c];
        end
        case (cfg.mode)
            MODE_COPY:     pix3_next = src2_reg;
            MODE_FADE_IN:  pix3_next = {8'h00, fade_in_rgb};
            MODE_FADE_OUT: pix3_next = {8'h00, fade_out_rgb};
            default:       pix3_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            src0_reg <= src_pixel;
            dst0_reg <= dest_pixel[23:0];
            sa0_reg  <= sa0_next;
            fo0_reg  <= fo0_next;
        end
        if (en[1])
        begin
            src1_reg <= src0_reg;
            dst1_reg <= dst0_reg;
            a1_reg   <= a1_next;
            fo1_reg  <= fo1_next;
        end
        if (en[2])
        begin
            src2_reg <= src1_reg;
            fo2_reg  <= fo1_reg;
            mix2_reg <= mix2_next;
        end
        if (en[3])
        begin
            pix3_reg <= pix3_next;
        end
    end

    assign pixel = pix3_reg;

endmodule

`default_nettype wire

// ===== rtl/lpc_checker.sv =====
`default_nettype none

module lpc_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    input  wire logic                          item_ready,
    input  wire logic                          result_valid,
    input  wire logic                          result_ready,
    input  wire logic                          write_enable,
    input  wire logic [lpc_pkg::ADDR_W-1:0]    address,
    input  wire logic [lpc_pkg::PIX_W-1:0]     out_pixel
);
    import lpc_pkg::*;

    // suppressed writes carry a zero payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !write_enable) |-> (address == '0 && out_pixel == '0))
        else $error("suppressed write with nonzero payload");

    // with the sink ready, an accepted request comes out once it has passed every pipeline stage
    assert property (@(posedge clk) disable iff (!rst_n)
        ($past(item_valid && item_ready, 4) && $past(rst_n, 1) && $past(rst_n, 2)
         && $past(rst_n, 3) && $past(rst_n, 4) && $past(result_ready, 1)
         && $past(result_ready, 2) && $past(result_ready, 3)) |-> result_valid)
        else $error("result missing after pipeline latency");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> result_valid)
        else $error("result valid dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
            ($stable(write_enable) && $stable(address) && $stable(out_pixel)))
        else $error("result payload changed while stalled");

endmodule

bind logo_pixel_compositor lpc_checker u_lpc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .write_enable (result.data.write_enable),
    .address      (result.data.address),
    .out_pixel    (result.data.out_pixel)
);

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import lpc_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 950;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int MAX_REPORTS  = 40;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    lpc_stream_if #(.T(lpc_item_t))   item_ch ();
    lpc_stream_if #(.T(lpc_result_t)) result_ch ();

    logo_pixel_compositor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    lpc_cfg_t    blend_cfg;
    lpc_item_t   pending_px[$];
    lpc_result_t expected_px[$];

    int errors       = 0;
    int cycles       = 0;
    int results_seen = 0;
    int writes_seen  = 0;
    int mode_reqs[4] = '{0, 0, 0, 0};
    int gap_left     = 0;
    int stall_left   = 0;
    bit item_taken   = 1'b0;
    bit steady       = 1'b0;

    always #4 clk = ~clk;

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 40);
    endfunction

    function automatic lpc_result_t composite(lpc_item_t px, lpc_cfg_t c);
        lpc_result_t r;
        logic [63:0] x, y, lin;
        logic [31:0] pix;
        int unsigned a, s, d;
        bit          ok;
        r   = '0;
        pix = '0;
        ok  = 1'b1;
        x   = 64'(px.col);
        y   = 64'(px.row);
        if (c.mode == MODE_COPY || c.mode == MODE_FADE_IN)
        begin
            x += 64'(c.offset_x);
            y += 64'(c.offset_y);
        end
        lin = y * 64'(c.frame_width) + x;
        case (c.mode)
            MODE_COPY:
                pix = px.src_pixel;
            MODE_FADE_IN:
            begin
                a = (32'(px.src_pixel[31:24]) * 32'(c.global_alpha)) / 255;
                for (int ch = 0; ch < 3; ch++)
                begin
                    s = 32'(px.src_pixel[8*ch +: 8]);
                    d = 32'(px.dest_pixel[8*ch +: 8]);
                    pix[8*ch +: 8] = 8'((s * a + d * (255 - a)) / 255);
                end
            end
            MODE_FADE_OUT:
                for (int ch = 0; ch < 3; ch++)
                begin
                    s = 32'(px.src_pixel[8*ch +: 8]);
                    pix[8*ch +: 8] = 8'((s * 32'(c.global_alpha)) / 255);
                end
            default:
                ok = 1'b0;
        endcase
        if (int'(px.col) >= MAX_DIM || int'(px.row) >= MAX_DIM)
            ok = 1'b0;
        if (lin >= 64'(c.frame_width) * 64'(c.frame_height))
            ok = 1'b0;
        if (lin > 64'hFF_FFFF)
            ok = 1'b0;
        if (ok)
        begin
            r.write_enable = 1'b1;
            r.address      = lin[ADDR_W-1:0];
            r.out_pixel    = pix;
        end
        return r;
    endfunction

    function automatic lpc_item_t pixel_req(logic [11:0] c, logic [11:0] r,
                                            logic [31:0] s, logic [31:0] d);
        lpc_item_t px;
        px.col        = c;
        px.row        = r;
        px.src_pixel  = s;
        px.dest_pixel = d;
        return px;
    endfunction

    function automatic lpc_cfg_t setting(logic [1:0] m, logic [7:0] ga,
                                         logic [12:0] ox, logic [12:0] oy,
                                         logic [12:0] fw, logic [12:0] fh);
        lpc_cfg_t c;
        c.mode         = m;
        c.global_alpha = ga;
        c.offset_x     = ox;
        c.offset_y     = oy;
        c.frame_width  = fw;
        c.frame_height = fh;
        return c;
    endfunction

    function automatic int pick_dim();
        int r;
        r = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0: return (r < 10) ? 0 : $urandom_range(1, 64);
            1: return (r < 10) ? 8191 : $urandom_range(1, 4096);
            2: return (r < 10) ? 4096 : $urandom_range(1, 1024);
            default: return (r < 10) ? 1 : $urandom_range(1, 4096);
        endcase
    endfunction

    function automatic int pick_offset(int dim);
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        else if (r < 85)
            return (dim > 1) ? $urandom_range(0, dim - 1) : 0;
        else if (r < 93)
            return 4096;
        else
            return $urandom_range(0, 8191);
    endfunction

    function automatic int pick_coord(int dim, int off);
        int top;
        if (off >= dim)
            return $urandom_range(0, 4095);
        top = dim - 1 - off;
        return $urandom_range(0, (top > 4095) ? 4095 : top);
    endfunction

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("mismatch on %s: got %h, want %h (cycle %0d)", field, got, want, cycles);
    endtask

    task automatic put_reg(lpc_cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        case (idx)
            CFG_MODE:         blend_cfg.mode         = v[1:0];
            CFG_GLOBAL_ALPHA: blend_cfg.global_alpha = v[7:0];
            CFG_OFFSET_X:     blend_cfg.offset_x     = v;
            CFG_OFFSET_Y:     blend_cfg.offset_y     = v;
            CFG_FRAME_WIDTH:  blend_cfg.frame_width  = v;
            CFG_FRAME_HEIGHT: blend_cfg.frame_height = v;
            default: ;
        endcase
    endtask

    // junk in the unused upper bits of the narrow registers must be dropped
    task automatic apply_config(lpc_cfg_t c, bit junk);
        put_reg(CFG_MODE, junk ? {11'($urandom), c.mode} : 13'(c.mode));
        put_reg(CFG_GLOBAL_ALPHA, junk ? {5'($urandom), c.global_alpha}
                                       : 13'(c.global_alpha));
        put_reg(CFG_OFFSET_X, c.offset_x);
        put_reg(CFG_OFFSET_Y, c.offset_y);
        put_reg(CFG_FRAME_WIDTH, c.frame_width);
        put_reg(CFG_FRAME_HEIGHT, c.frame_height);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_px.size() != 0 || item_ch.valid || expected_px.size() != 0);
        repeat (STAGES + 2) @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    always @(negedge clk)
    begin : feeder
        if (!rst_n)
            item_ch.valid <= 1'b0;
        else if (!item_ch.valid || item_taken)
        begin
            if (gap_left > 0)
            begin
                item_ch.valid <= 1'b0;
                gap_left      <= gap_left - 1;
            end
            else if (pending_px.size() > 0)
            begin
                item_ch.data  <= pending_px.pop_front();
                item_ch.valid <= 1'b1;
                gap_left      <= steady ? 0 : draw_gap();
            end
            else
                item_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin : backpressure
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            result_ch.ready <= 1'b0;
            stall_left      <= stall_left - 1;
        end
        else
        begin
            result_ch.ready <= 1'b1;
            if (!steady && $urandom_range(0, 99) < 25)
                stall_left <= draw_gap();
        end
    end

    always @(posedge clk)
    begin : monitor
        lpc_result_t got, want;
        if (!rst_n)
            item_taken <= 1'b0;
        else
        begin
            item_taken <= item_ch.valid && item_ch.ready;
            if (item_ch.valid && item_ch.ready)
            begin
                expected_px.push_back(composite(item_ch.data, blend_cfg));
                mode_reqs[blend_cfg.mode]++;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                got = result_ch.data;
                results_seen++;
                if (got.write_enable === 1'b1)
                    writes_seen++;
                if (expected_px.size() == 0)
                    report("unrequested result", 32'(got.address), 32'h0);
                else
                begin
                    want = expected_px.pop_front();
                    if (got.write_enable !== want.write_enable)
                        report("write_enable", 32'(got.write_enable),
                               32'(want.write_enable));
                    if (got.address !== want.address)
                        report("address", 32'(got.address), 32'(want.address));
                    if (got.out_pixel !== want.out_pixel)
                        report("out_pixel", got.out_pixel, want.out_pixel);
                end
            end
        end
    end

    initial
    begin : stimulus
        lpc_cfg_t   c;
        logic [1:0] m;
        int         r, n, fw, fh, ox, oy, xo, yo, sent, phases;
        logic [31:0] s;

        item_ch.valid   = 1'b0;
        item_ch.data    = '0;
        result_ch.ready = 1'b0;
        blend_cfg       = setting(MODE_COPY, 8'd255, 13'd0, 13'd0, 13'd1024, 13'd768);
        sent            = 0;
        phases          = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // register defaults straight out of reset: copy into 1024x768
        pending_px.push_back(pixel_req(0, 0, 32'h0000_0000, 32'hFFFF_FFFF));
        pending_px.push_back(pixel_req(1023, 767, 32'hFFFF_FFFF, 32'h0));
        pending_px.push_back(pixel_req(1024, 0, 32'h1234_5678, 32'h0));
        pending_px.push_back(pixel_req(0, 768, 32'hFFFF_FFFF, 32'h0));
        pending_px.push_back(pixel_req(4095, 4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_px.push_back(pixel_req(12'hAAA, 12'h155, 32'hA5A5_5A5A, 32'h5A5A_A5A5));
        wait_idle();

        apply_config(setting(MODE_FADE_IN, 8'd255, 13'd3, 13'd2, 13'd64, 13'd64), 1'b1);
        pending_px.push_back(pixel_req(0, 0, 32'hFFFF_8000, 32'h0000_FF00));
        pending_px.push_back(pixel_req(60, 61, 32'h00FF_FFFF, 32'hFFFF_FFFF));
        pending_px.push_back(pixel_req(61, 0, 32'h8010_2030, 32'h40F0_E0D0));
        pending_px.push_back(pixel_req(5, 5, 32'hFF00_0000, 32'hFFFF_FFFF));
        wait_idle();

        apply_config(setting(MODE_FADE_IN, 8'd0, 13'd0, 13'd0, 13'd4096, 13'd4096), 1'b0);
        pending_px.push_back(pixel_req(4095, 4095, 32'hFFFF_FFFF, 32'h1234_5678));
        pending_px.push_back(pixel_req(1, 2, 32'h7F80_C0FF, 32'h0102_0304));
        wait_idle();

        // fade-out ignores the offsets
        apply_config(setting(MODE_FADE_OUT, 8'd128, 13'd100, 13'd100, 13'd16, 13'd16), 1'b0);
        pending_px.push_back(pixel_req(15, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_px.push_back(pixel_req(0, 0, 32'h8080_8080, 32'h0));
        pending_px.push_back(pixel_req(16, 15, 32'h0000_0000, 32'h0));
        wait_idle();

        apply_config(setting(MODE_FADE_OUT, 8'd255, 13'd0, 13'd0, 13'd1, 13'd1), 1'b1);
        pending_px.push_back(pixel_req(0, 0, 32'hFF12_3456, 32'hFFFF_FFFF));
        wait_idle();

        apply_config(setting(MODE_UNUSED, 8'd255, 13'd0, 13'd0, 13'd1024, 13'd768), 1'b0);
        pending_px.push_back(pixel_req(0, 0, 32'hFFFF_FFFF, 32'h0));
        pending_px.push_back(pixel_req(7, 9, 32'h1234_5678, 32'h0));
        wait_idle();

        apply_config(setting(MODE_COPY, 8'd255, 13'd0, 13'd0, 13'd0, 13'd768), 1'b0);
        pending_px.push_back(pixel_req(0, 0, 32'hFFFF_FFFF, 32'h0));
        wait_idle();

        // address past 24 bits and also past width*height
        apply_config(setting(MODE_COPY, 8'd255, 13'd8191, 13'd8191, 13'd8191, 13'd8191),
                     1'b0);
        pending_px.push_back(pixel_req(4095, 4095, 32'hDEAD_BEEF, 32'h0));
        pending_px.push_back(pixel_req(0, 0, 32'hCAFE_F00D, 32'h0));
        wait_idle();

        apply_config(setting(MODE_COPY, 8'd255, 13'd4096, 13'd0, 13'd4096, 13'd1), 1'b0);
        pending_px.push_back(pixel_req(0, 0, 32'h0F0F_0F0F, 32'h0));
        wait_idle();

        while (sent < RANDOM_ITEMS)
        begin
            phases++;
            r  = $urandom_range(0, 99);
            m  = (r < 30) ? MODE_COPY : (r < 60) ? MODE_FADE_IN :
                 (r < 93) ? MODE_FADE_OUT : MODE_UNUSED;
            fw = pick_dim();
            fh = pick_dim();
            ox = pick_offset(fw);
            oy = pick_offset(fh);
            r  = $urandom_range(0, 99);
            c  = setting(m, (r < 15) ? 8'd0 : (r < 30) ? 8'd255 : 8'($urandom),
                         13'(ox), 13'(oy), 13'(fw), 13'(fh));
            apply_config(c, 1'($urandom_range(0, 1)));
            steady = ($urandom_range(0, 4) == 0);
            xo = (m == MODE_FADE_OUT) ? 0 : ox;
            yo = (m == MODE_FADE_OUT) ? 0 : oy;
            n  = $urandom_range(40, 110);
            if (n > RANDOM_ITEMS - sent)
                n = RANDOM_ITEMS - sent;
            for (int i = 0; i < n; i++)
            begin
                s = $urandom;
                r = $urandom_range(0, 99);
                if (r < 8)
                    s[31:24] = 8'h00;
                else if (r < 16)
                    s[31:24] = 8'hFF;
                if ($urandom_range(0, 99) < 80)
                    pending_px.push_back(pixel_req(12'(pick_coord(fw, xo)),
                                                   12'(pick_coord(fh, yo)),
                                                   s, $urandom));
                else
                    pending_px.push_back(pixel_req(12'($urandom), 12'($urandom), s,
                                                   $urandom));
            end
            sent += n;
            wait_idle();
        end
        steady = 1'b0;

        $display("run covered %0d requests in %0d random settings; %0d of %0d results wrote",
                 mode_reqs[0] + mode_reqs[1] + mode_reqs[2] + mode_reqs[3], phases,
                 writes_seen, results_seen);
        $display("requests per mode: copy %0d, fade-in %0d, fade-out %0d, unused %0d",
                 mode_reqs[0], mode_reqs[1], mode_reqs[2], mode_reqs[3]);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
